>>> sv/pes_pkg.sv
// Shared types, constants and the microcode program of the polygon edge subdivider.
`default_nettype none

package pes_pkg;

    localparam int PES_MAX_SUB_DEF = 16;
    localparam int PES_COORD_W_DEF = 16;
    localparam int PES_AMT_W       = 5;

    typedef logic [3:0] t_upc;

    // Program step addresses.
    localparam t_upc UPC_WAIT     = 4'd0;
    localparam t_upc UPC_CHECK    = 4'd1;
    localparam t_upc UPC_EDGE     = 4'd2;
    localparam t_upc UPC_DIV_LOAD = 4'd3;
    localparam t_upc UPC_DIV_STEP = 4'd4;
    localparam t_upc UPC_DIV_FIX  = 4'd5;
    localparam t_upc UPC_EMIT     = 4'd6;
    localparam t_upc UPC_AFTER    = 4'd7;
    localparam t_upc UPC_CLOSE    = 4'd8;
    localparam t_upc UPC_FIRST    = 4'd9;
    localparam t_upc UPC_TO_CLOSE = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_EDGE,
        OP_FIRST,
        OP_CLOSE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_EMIT,
        OP_AFTER
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_NO_PREV,
        C_DIV_MORE,
        C_EMIT_AGAIN,
        C_RUN_DONE,
        C_NOT_LAST
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_ctrl_word;

    typedef struct packed {
        logic no_prev;
        logic div_more;
        logic emit_again;
        logic run_done;
        logic cur_last;
    } t_dp_status;

    // Control store: jump to target when cond holds, else step on.
    function automatic t_ctrl_word f_ucode(input t_upc pc);
        t_ctrl_word w;
        case (pc)
            UPC_WAIT:     w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,   target: UPC_WAIT};
            UPC_CHECK:    w = '{op: OP_NOP,      cond: C_NO_PREV,    target: UPC_FIRST};
            UPC_EDGE:     w = '{op: OP_EDGE,     cond: C_NEXT,       target: UPC_WAIT};
            UPC_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: C_NEXT,       target: UPC_WAIT};
            UPC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: UPC_DIV_STEP};
            UPC_DIV_FIX:  w = '{op: OP_DIV_FIX,  cond: C_NEXT,       target: UPC_WAIT};
            UPC_EMIT:     w = '{op: OP_EMIT,     cond: C_EMIT_AGAIN, target: UPC_EMIT};
            UPC_AFTER:    w = '{op: OP_AFTER,    cond: C_RUN_DONE,   target: UPC_WAIT};
            UPC_CLOSE:    w = '{op: OP_CLOSE,    cond: C_ALWAYS,     target: UPC_DIV_LOAD};
            UPC_FIRST:    w = '{op: OP_FIRST,    cond: C_NOT_LAST,   target: UPC_WAIT};
            UPC_TO_CLOSE: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: UPC_CLOSE};
            default:      w = '{op: OP_NOP,      cond: C_ALWAYS,     target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/pes_ucode_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module pes_ucode_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire pes_pkg::t_dp_status i_status,
    output pes_pkg::t_ctrl_word      o_ctrl
);
    import pes_pkg::*;

    t_upc       r_pc;
    t_upc       n_pc;
    t_ctrl_word w_word;
    logic       w_take;

    assign w_word = f_ucode(r_pc);
    assign o_ctrl = w_word;

    always_comb begin
        case (w_word.cond)
            C_NEXT:       w_take = 1'b0;
            C_ALWAYS:     w_take = 1'b1;
            C_NO_INPUT:   w_take = !i_in_valid;
            C_NO_PREV:    w_take = i_status.no_prev;
            C_DIV_MORE:   w_take = i_status.div_more;
            C_EMIT_AGAIN: w_take = i_status.emit_again;
            C_RUN_DONE:   w_take = i_status.run_done;
            C_NOT_LAST:   w_take = !i_status.cur_last;
            default:      w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : r_pc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Hold for input only in the wait step.
    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_WAIT && !i_in_valid) |=> (r_pc == UPC_WAIT))
        else $error("sequencer left the wait step without an input");

    // After the divide loop the fix-up step always follows.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_DIV_STEP && !i_status.div_more) |=> (r_pc == UPC_DIV_FIX))
        else $error("divide loop did not exit to the fix-up step");

    // The first vertex of a polygon takes the store path and emits no edge from a previous vertex.
    a_first_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_CHECK && i_status.no_prev) |=> (r_pc == UPC_FIRST))
        else $error("first vertex did not take the store path");

endmodule

`default_nettype wire

>>> sv/pes_datapath.sv
// Datapath: vertex store, bit-serial divider, point stepper and output register.
`default_nettype none

module pes_datapath #(
    parameter int MAX_SUBDIVISION = pes_pkg::PES_MAX_SUB_DEF,
    parameter int COORD_WIDTH     = pes_pkg::PES_COORD_W_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pes_pkg::t_ctrl_word             i_ctrl,
    output pes_pkg::t_dp_status                  o_status,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [pes_pkg::PES_AMT_W-1:0]   i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    input  wire logic signed [COORD_WIDTH-1:0]   i_vx,
    input  wire logic signed [COORD_WIDTH-1:0]   i_vy,
    input  wire logic                            i_vlast,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [COORD_WIDTH-1:0]        o_px,
    output logic signed [COORD_WIDTH-1:0]        o_py,
    output logic                                 o_last,
    output logic                                 o_end
);
    import pes_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_SUBDIVISION + 1);
    localparam int NW   = CW + 1;
    localparam int QW   = CW + 2;
    localparam int CNTW = $clog2(CW + 2);
    localparam int FW   = (AW > PES_AMT_W) ? AW : PES_AMT_W;

    // Lane 0 carries x, lane 1 carries y.
    logic signed [CW-1:0] r_first [2];
    logic signed [CW-1:0] r_prev  [2];
    logic signed [CW-1:0] r_cur   [2];
    logic signed [NW-1:0] r_diff  [2];
    logic        [NW-1:0] r_dvq   [2];
    logic        [AW-1:0] r_dvr   [2];
    logic                 r_neg   [2];
    logic signed [QW-1:0] r_q     [2];
    logic        [AW-1:0] r_r     [2];
    logic signed [QW-1:0] r_dq    [2];
    logic        [AW-1:0] r_dr    [2];

    logic [PES_AMT_W-1:0] r_cfg;
    logic [AW-1:0]        r_amt;
    logic [AW-1:0]        r_k;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_have_prev;
    logic                 r_cur_last;
    logic                 r_closing;

    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_x;
    logic signed [CW-1:0] r_out_y;
    logic                 r_out_last;
    logic                 r_out_end;

    logic signed [CW-1:0] w_in    [2];
    logic signed [NW-1:0] w_de    [2];
    logic signed [NW-1:0] w_dc    [2];
    logic        [NW-1:0] w_mag   [2];
    logic        [AW:0]   w_trial [2];
    logic                 w_ge    [2];
    logic        [AW:0]   w_tsub  [2];
    logic signed [QW-1:0] w_qpos  [2];
    logic signed [QW-1:0] w_fdq   [2];
    logic        [AW-1:0] w_fdr   [2];
    logic signed [QW-1:0] w_pt    [2];
    logic        [AW:0]   w_rsum  [2];
    logic                 w_wrap  [2];
    logic        [AW:0]   w_rsub  [2];
    logic signed [QW-1:0] w_qnext [2];

    logic [FW-1:0] w_cfg_ext;
    logic [AW-1:0] w_amt_eff;
    logic          w_slot_free;
    logic          w_last_pt;
    logic          w_emit_fire;

    assign w_in[0] = i_vx;
    assign w_in[1] = i_vy;

    // Clamp the amount to 1..MAX_SUBDIVISION.
    always_comb begin
        w_cfg_ext = FW'(r_cfg);
        if (w_cfg_ext == '0) begin
            w_amt_eff = AW'(1);
        end else if (w_cfg_ext > FW'(MAX_SUBDIVISION)) begin
            w_amt_eff = AW'(MAX_SUBDIVISION);
        end else begin
            w_amt_eff = AW'(w_cfg_ext);
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last_pt   = (r_k == r_amt - AW'(1));
    assign w_emit_fire = (i_ctrl.op == OP_EMIT) && w_slot_free;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_de[l]    = $signed({r_cur[l][CW-1], r_cur[l]})
                       - $signed({r_prev[l][CW-1], r_prev[l]});
            w_dc[l]    = $signed({r_first[l][CW-1], r_first[l]})
                       - $signed({r_cur[l][CW-1], r_cur[l]});
            w_mag[l]   = r_diff[l][NW-1] ? NW'(-r_diff[l]) : NW'(r_diff[l]);
            // Restoring divide, one quotient bit a step.
            w_trial[l] = {r_dvr[l], r_dvq[l][NW-1]};
            w_ge[l]    = (w_trial[l] >= {1'b0, r_amt});
            w_tsub[l]  = w_trial[l] - {1'b0, r_amt};
            // Floor quotient and remainder of the edge step.
            w_qpos[l]  = $signed({1'b0, r_dvq[l]});
            if (r_neg[l] && r_dvr[l] != '0) begin
                w_fdq[l] = -(w_qpos[l] + QW'(1));
                w_fdr[l] = r_amt - r_dvr[l];
            end else if (r_neg[l]) begin
                w_fdq[l] = -w_qpos[l];
                w_fdr[l] = r_dvr[l];
            end else begin
                w_fdq[l] = w_qpos[l];
                w_fdr[l] = r_dvr[l];
            end
            // Floor to truncation toward zero.
            w_pt[l]    = (r_q[l] < 0 && r_r[l] != '0) ? r_q[l] + QW'(1) : r_q[l];
            w_rsum[l]  = {1'b0, r_r[l]} + {1'b0, r_dr[l]};
            w_wrap[l]  = (w_rsum[l] >= {1'b0, r_amt});
            w_rsub[l]  = w_rsum[l] - {1'b0, r_amt};
            w_qnext[l] = r_q[l] + r_dq[l] + (w_wrap[l] ? QW'(1) : QW'(0));
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= PES_AMT_W'(1);
            r_have_prev <= 1'b0;
            r_closing   <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            case (i_ctrl.op)
                OP_EDGE:     r_closing   <= 1'b0;
                OP_FIRST:    r_have_prev <= 1'b1;
                OP_CLOSE:    r_closing   <= 1'b1;
                OP_DIV_LOAD: begin
                    r_cnt <= CNTW'(NW);
                    r_k   <= '0;
                end
                OP_DIV_STEP: r_cnt <= r_cnt - CNTW'(1);
                OP_EMIT: begin
                    if (w_slot_free) begin
                        r_k <= r_k + AW'(1);
                    end
                end
                OP_AFTER: begin
                    if (r_closing) begin
                        r_have_prev <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (w_emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_cur[0]   <= w_in[0];
                    r_cur[1]   <= w_in[1];
                    r_cur_last <= i_vlast;
                    r_amt      <= w_amt_eff;
                end
            end
            OP_EDGE: begin
                for (int l = 0; l < 2; l++) begin
                    r_diff[l] <= w_de[l];
                    r_q[l]    <= QW'(r_prev[l]);
                    r_r[l]    <= '0;
                    r_prev[l] <= r_cur[l];
                end
            end
            OP_FIRST: begin
                for (int l = 0; l < 2; l++) begin
                    r_first[l] <= r_cur[l];
                    r_prev[l]  <= r_cur[l];
                end
            end
            OP_CLOSE: begin
                for (int l = 0; l < 2; l++) begin
                    r_diff[l] <= w_dc[l];
                    r_q[l]    <= QW'(r_cur[l]);
                    r_r[l]    <= '0;
                end
            end
            OP_DIV_LOAD: begin
                for (int l = 0; l < 2; l++) begin
                    r_dvq[l] <= w_mag[l];
                    r_dvr[l] <= '0;
                    r_neg[l] <= r_diff[l][NW-1];
                end
            end
            OP_DIV_STEP: begin
                for (int l = 0; l < 2; l++) begin
                    r_dvq[l] <= {r_dvq[l][NW-2:0], w_ge[l]};
                    r_dvr[l] <= w_ge[l] ? w_tsub[l][AW-1:0] : w_trial[l][AW-1:0];
                end
            end
            OP_DIV_FIX: begin
                for (int l = 0; l < 2; l++) begin
                    r_dq[l] <= w_fdq[l];
                    r_dr[l] <= w_fdr[l];
                end
            end
            OP_EMIT: begin
                if (w_slot_free) begin
                    r_out_x    <= w_pt[0][CW-1:0];
                    r_out_y    <= w_pt[1][CW-1:0];
                    r_out_last <= w_last_pt && (r_closing || !r_cur_last);
                    r_out_end  <= w_last_pt && r_closing;
                    for (int l = 0; l < 2; l++) begin
                        r_q[l] <= w_qnext[l];
                        r_r[l] <= w_wrap[l] ? w_rsub[l][AW-1:0] : w_rsum[l][AW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_status.no_prev    = !r_have_prev;
    assign o_status.div_more   = (r_cnt != CNTW'(1));
    assign o_status.emit_again = !(w_slot_free && w_last_pt);
    assign o_status.run_done   = r_closing || !r_cur_last;
    assign o_status.cur_last   = r_cur_last;

    assign o_out_valid = r_out_valid;
    assign o_px        = r_out_x;
    assign o_py        = r_out_y;
    assign o_last      = r_out_last;
    assign o_end       = r_out_end;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DIV_STEP) |-> (r_dvr[0] < r_amt && r_dvr[1] < r_amt))
        else $error("divider partial remainder out of range");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT) |-> (r_k < r_amt))
        else $error("point index ran past the amount");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DIV_STEP) |-> (r_cnt != '0))
        else $error("divide step with an exhausted counter");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_last)
        else $error("polygon end without end of run");

endmodule

`default_nettype wire

>>> sv/polygon_edge_subdivider.sv
// Top level of the closed polygon edge subdivider.
// Usage:
//   Vertices of one closed polygon enter on the s_axis group, x in tdata's low
//   half, y above it, tlast on the final vertex. Each vertex after the first
//   yields the edge from the previous vertex: the start vertex, then amount-1
//   evenly spaced points, each truncated toward zero. The final vertex also
//   yields the closing edge back to the first vertex. Points leave on the
//   m_axis group; tlast marks the final point caused by a vertex, tuser the
//   final point of the polygon.
//   The amount is written through i_cfg_wr_en / i_cfg_wr_data while idle;
//   0 acts as 1, values above MAX_SUBDIVISION saturate.
// Timing:
//   One vertex at a time. Each edge costs a bit-serial divide of the
//   (COORD_WIDTH+1)-bit edge step by the amount, set-up and wrap-up steps
//   and one point per cycle while the receiver takes them. A later vertex
//   processes its edge, the last one the closing edge too; a first vertex
//   is only stored, unless it is also the last, when it takes the closing
//   edge. A stalled receiver holds the output register and the point
//   stepper; nothing is lost. Reset clears the open polygon, sets the
//   amount to 1 and holds s_axis tready low.
`default_nettype none

module polygon_edge_subdivider #(
    parameter int MAX_SUBDIVISION = pes_pkg::PES_MAX_SUB_DEF,
    parameter int COORD_WIDTH     = pes_pkg::PES_COORD_W_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_cfg_wr_en,
    input  wire logic [pes_pkg::PES_AMT_W-1:0]             i_cfg_wr_data,
    input  wire logic                                      i_s_tvalid,
    output logic                                           o_s_tready,
    // vertex_x, vertex_y (low bits up), zero padded to whole bytes
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    input  wire logic                                      i_s_tlast,
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    // point_x, point_y (low bits up), zero padded to whole bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]             o_m_tdata,
    output logic                                           o_m_tlast,
    // polygon_end
    output logic                                           o_m_tuser
);
    import pes_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = ((2 * CW + 7) / 8) * 8;

    t_ctrl_word           w_ctrl;
    t_dp_status           w_status;
    logic signed [CW-1:0] w_px;
    logic signed [CW-1:0] w_py;

    // Take a vertex only in the wait step of the program, never in reset.
    assign o_s_tready = (w_ctrl.op == OP_ACCEPT) && i_rst_n;

    pes_ucode_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    pes_datapath #(
        .MAX_SUBDIVISION (MAX_SUBDIVISION),
        .COORD_WIDTH     (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_tvalid),
        .i_vx          (i_s_tdata[CW-1:0]),
        .i_vy          (i_s_tdata[2*CW-1:CW]),
        .i_vlast       (i_s_tlast),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_px          (w_px),
        .o_py          (w_py),
        .o_last        (o_m_tlast),
        .o_end         (o_m_tuser)
    );

    // Pack y above x; pad bits stay zero.
    assign o_m_tdata = DW'({w_py, w_px});

endmodule

`default_nettype wire
